FILE: rtl/rlh_pkg.sv
// Payload types shared by the lightness-adjust block and its checker.
package rlh_pkg;

    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
        logic [7:0] level;
    } in_t;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
    } out_t;

    // Levels at and above this clamp to it (lightness 0.995).
    localparam logic [7:0] LEVEL_MAX  = 8'd199;
    // Level at which lightness reaches one half.
    localparam logic [7:0] LEVEL_HALF = 8'd100;

endpackage

FILE: rtl/rgb_lightness_via_hsl.sv
// RGB lightness adjustment through HSL, pipelined with bit-serial dividers.
//
//  channel | signals                            | direction
//  --------+------------------------------------+----------
//  item    | item_valid, item_ready, item       | in
//  result  | result_valid, result_ready, result | out
//
// One item per cycle when the result side keeps up.
// After the input register come a setup register,
// FRAC_BITS + 8 divider stages (one quotient bit each, hue and saturation side
// by side), four math stages and the result register.
// All stages move together; a stalled result freezes the whole pipeline.
// Reset clears the valid bits only.
module rgb_lightness_via_hsl #(
    parameter int FRAC_BITS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          item_valid,
    output logic          item_ready,
    input  rlh_pkg::in_t  item,
    output logic          result_valid,
    input  logic          result_ready,
    output rlh_pkg::out_t result
);

    localparam int F  = FRAC_BITS;
    localparam int QW = F + 8;       // quotient bits
    localparam int DW = 2 * F + 17;  // remainder / trial width
    localparam int VW = F + 9;       // signed q, p
    localparam int TW = F + 3;       // signed hue position

    localparam logic signed [TW-1:0] ONE  = TW'(64'd1 << F);
    localparam logic signed [TW-1:0] HALF = TW'(64'd1 << (F - 1));
    localparam logic signed [TW-1:0] K17  = TW'((64'd17 << F) / 64'd100);
    localparam logic signed [TW-1:0] K33  = TW'((64'd33 << F) / 64'd100);
    localparam logic signed [TW-1:0] K67  = TW'((64'd67 << F) / 64'd100);

    typedef enum logic [1:0] {
        RG_RISE = 2'd0,
        RG_TOP  = 2'd1,
        RG_FALL = 2'd2,
        RG_LOW  = 2'd3
    } rg_t;

    typedef struct packed {
        rg_t        rg;
        logic [F:0] f;
    } sel_t;

    logic en;
    assign en         = !result_valid || result_ready;
    assign item_ready = en;

    // lightness table: floor(level * 2^F / 200)
    logic [F-1:0] lf_tab [256];
    for (genvar gi = 0; gi < 256; gi++) begin : g_lf
        assign lf_tab[gi] = F'((64'(gi) << F) / 64'd200);
    end

    // ---------------- input stage
    logic          a_valid_reg;
    rlh_pkg::in_t  a_item_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            a_valid_reg <= 1'b0;
        end
        else if (en) begin
            a_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            a_item_reg <= item;
        end
    end

    // ---------------- setup of both divisions
    logic [7:0]    r, g, b, mx, mn, d, lv;
    logic [10:0]   num, d6;
    logic [F-1:0]  lf;
    logic [F:0]    om;
    logic [DW-1:0] hn_next, hd_next, sn_next, sd_next;

    always_comb begin
        r  = a_item_reg.red_in;
        g  = a_item_reg.green_in;
        b  = a_item_reg.blue_in;
        mx = r;
        mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        d  = mx - mn;
        d6 = {1'b0, d, 2'b00} + {2'b00, d, 1'b0};
        priority if (mx == r && g >= b) num = 11'(g) - 11'(b);
        else if (mx == r)               num = d6 - (11'(b) - 11'(g));
        else if (mx == g)               num = 11'(b) + {2'b00, d, 1'b0} - 11'(r);
        else                            num = 11'(r) + {1'b0, d, 2'b00} - 11'(g);

        lv = (a_item_reg.level > rlh_pkg::LEVEL_MAX) ? rlh_pkg::LEVEL_MAX
                                                     : a_item_reg.level;
        lf = lf_tab[lv];
        om = (F+1)'(64'd1 << F) - (F+1)'(lf);

        if (d == 8'd0) begin
            hn_next = '0;
            hd_next = DW'(1);
        end
        else begin
            hn_next = DW'(num) << F;
            hd_next = DW'(d6);
        end

        if (d == 8'd0 || lv == 8'd0) begin
            sn_next = '0;
            sd_next = DW'(1);
        end
        else if (lv <= rlh_pkg::LEVEL_HALF) begin
            sn_next = DW'(d) << F;
            sd_next = DW'(9'(mx) + 9'(mn));
        end
        else begin
            // 510 * (1 - lf)
            sn_next = DW'(d) << (2 * F);
            sd_next = (DW'(om) << 9) - (DW'(om) << 1);
        end
    end

    // ---------------- divider pipeline, one quotient bit per stage
    logic          dv_valid_reg [QW+1];
    logic [DW-1:0] hrem_reg [QW+1];
    logic [DW-1:0] hdiv_reg [QW+1];
    logic [QW-1:0] hquo_reg [QW+1];
    logic [DW-1:0] srem_reg [QW+1];
    logic [DW-1:0] sdiv_reg [QW+1];
    logic [QW-1:0] squo_reg [QW+1];
    logic [F-1:0]  dlf_reg  [QW+1];
    logic          dlt_reg  [QW+1];

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            dv_valid_reg[0] <= 1'b0;
        end
        else if (en) begin
            dv_valid_reg[0] <= a_valid_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            hrem_reg[0] <= hn_next;
            hdiv_reg[0] <= hd_next;
            hquo_reg[0] <= '0;
            srem_reg[0] <= sn_next;
            sdiv_reg[0] <= sd_next;
            squo_reg[0] <= '0;
            dlf_reg[0]  <= lf;
            dlt_reg[0]  <= (lv < rlh_pkg::LEVEL_HALF);
        end
    end

    for (genvar gj = 0; gj < QW; gj++) begin : g_div
        localparam int SH = QW - 1 - gj;
        logic [DW-1:0] htrial, strial;
        logic          hge, sge;

        assign htrial = hdiv_reg[gj] << SH;
        assign strial = sdiv_reg[gj] << SH;
        assign hge    = hrem_reg[gj] >= htrial;
        assign sge    = srem_reg[gj] >= strial;

        always_ff @(posedge clk or negedge rst_n) begin
            if (!rst_n) begin
                dv_valid_reg[gj+1] <= 1'b0;
            end
            else if (en) begin
                dv_valid_reg[gj+1] <= dv_valid_reg[gj];
            end
        end

        always_ff @(posedge clk) begin
            if (en) begin
                hrem_reg[gj+1] <= hge ? hrem_reg[gj] - htrial : hrem_reg[gj];
                hdiv_reg[gj+1] <= hdiv_reg[gj];
                hquo_reg[gj+1] <= {hquo_reg[gj][QW-2:0], hge};
                srem_reg[gj+1] <= sge ? srem_reg[gj] - strial : srem_reg[gj];
                sdiv_reg[gj+1] <= sdiv_reg[gj];
                squo_reg[gj+1] <= {squo_reg[gj][QW-2:0], sge};
                dlf_reg[gj+1]  <= dlf_reg[gj];
                dlt_reg[gj+1]  <= dlt_reg[gj];
            end
        end
    end

    // ---------------- stage B: s * lf
    logic            b_valid_reg;
    logic [QW+F-1:0] b_prod_reg;
    logic [QW-1:0]   b_s_reg;
    logic [F-1:0]    b_lf_reg, b_hf_reg;
    logic            b_lt_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            b_valid_reg <= 1'b0;
        end
        else if (en) begin
            b_valid_reg <= dv_valid_reg[QW];
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            b_prod_reg <= squo_reg[QW] * dlf_reg[QW];
            b_s_reg    <= squo_reg[QW];
            b_lf_reg   <= dlf_reg[QW];
            b_hf_reg   <= hquo_reg[QW][F-1:0];
            b_lt_reg   <= dlt_reg[QW];
        end
    end

    // ---------------- stage C: q, p and curve segment per channel
    function automatic sel_t chan_sel(input logic signed [TW-1:0] t);
        sel_t                    o;
        logic signed [TW-1:0]    w;
        logic signed [TW+2:0]    x6;
        begin
            w = t;
            if (w < 0)
                w = w + ONE;
            else if (w > ONE)
                w = w - ONE;
            o.f = '0;
            priority if (w < K17) begin
                o.rg = RG_RISE;
                x6   = (TW+3)'(w) * (TW+3)'(6);
                o.f  = x6[F:0];
            end
            else if (w < HALF) begin
                o.rg = RG_TOP;
            end
            else if (w < K67) begin
                o.rg = RG_FALL;
                x6   = (TW+3)'(K67 - w) * (TW+3)'(6);
                o.f  = x6[F:0];
            end
            else begin
                o.rg = RG_LOW;
            end
            return o;
        end
    endfunction

    logic [QW-1:0]        ls;
    logic signed [VW-1:0] q_next, p_next;
    logic signed [TW-1:0] hft;
    sel_t                 sel_next [3];

    always_comb begin
        ls  = b_prod_reg[QW+F-1:F];
        if (b_lt_reg)
            q_next = signed'(VW'(b_lf_reg) + VW'(ls));
        else
            q_next = signed'(VW'(b_lf_reg) + VW'(b_s_reg) - VW'(ls));
        p_next = signed'(VW'(b_lf_reg) << 1) - q_next;
        hft    = signed'(TW'(b_hf_reg));
        sel_next[0] = chan_sel(hft + K33);
        sel_next[1] = chan_sel(hft);
        sel_next[2] = chan_sel(hft - K33);
    end

    logic                 c_valid_reg;
    logic signed [VW-1:0] c_q_reg, c_p_reg;
    sel_t                 c_sel_reg [3];

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            c_valid_reg <= 1'b0;
        end
        else if (en) begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            c_q_reg   <= q_next;
            c_p_reg   <= p_next;
            c_sel_reg <= sel_next;
        end
    end

    // ---------------- stage D: (q - p) * factor, both non-negative
    logic [VW-1:0] diff;
    assign diff = VW'(c_q_reg - c_p_reg);

    logic                 d_valid_reg;
    logic [2*F+8:0]       d_mp_reg [3];
    logic signed [VW-1:0] d_q_reg, d_p_reg;
    rg_t                  d_rg_reg [3];

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            d_valid_reg <= 1'b0;
        end
        else if (en) begin
            d_valid_reg <= c_valid_reg;
        end
    end

    for (genvar gk = 0; gk < 3; gk++) begin : g_mul
        always_ff @(posedge clk) begin
            if (en) begin
                d_mp_reg[gk] <= diff[VW-2:0] * c_sel_reg[gk].f;
                d_rg_reg[gk] <= c_sel_reg[gk].rg;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            d_q_reg <= c_q_reg;
            d_p_reg <= c_p_reg;
        end
    end

    // ---------------- stage E: channel value
    logic                 e_valid_reg;
    logic signed [VW:0]   e_v_reg [3];

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            e_valid_reg <= 1'b0;
        end
        else if (en) begin
            e_valid_reg <= d_valid_reg;
        end
    end

    for (genvar gk = 0; gk < 3; gk++) begin : g_val
        logic signed [VW:0] v_next;
        always_comb begin
            unique case (d_rg_reg[gk])
                RG_RISE, RG_FALL:
                    v_next = (VW+1)'(d_p_reg)
                           + signed'((VW+1)'(d_mp_reg[gk][2*F+8:F]));
                RG_TOP:  v_next = (VW+1)'(d_q_reg);
                RG_LOW:  v_next = (VW+1)'(d_p_reg);
                default: v_next = (VW+1)'(d_p_reg);
            endcase
        end
        always_ff @(posedge clk) begin
            if (en) begin
                e_v_reg[gk] <= v_next;
            end
        end
    end

    // ---------------- duty: 255 * v >> F, saturated
    function automatic logic [7:0] to_duty(input logic signed [VW:0] v);
        logic [VW+8:0] x;
        logic [VW+8:0] y;
        begin
            x = ((VW+9)'(v) << 8) - (VW+9)'(v);
            y = x >> F;
            if (v <= 0)
                return 8'd0;
            else if (y > (VW+9)'(255))
                return 8'd255;
            else
                return y[7:0];
        end
    endfunction

    logic          out_valid_reg;
    rlh_pkg::out_t out_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end
        else if (en) begin
            out_valid_reg <= e_valid_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            out_reg.red_out   <= to_duty(e_v_reg[0]);
            out_reg.green_out <= to_duty(e_v_reg[1]);
            out_reg.blue_out  <= to_duty(e_v_reg[2]);
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

FILE: rtl/rlh_checker.sv
// Port-level checks for the lightness-adjust block, bound to the top level.
module rlh_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          item_valid,
    input logic          item_ready,
    input rlh_pkg::in_t  item,
    input logic          result_valid,
    input logic          result_ready,
    input rlh_pkg::out_t result
);

    // a held result stays put
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    a_reset: assert property (@(posedge clk) !rst_n |=> !result_valid)
        else $error("result valid during reset");

    // pipeline takes an item exactly when the result register can move
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        item_ready == (!result_valid || result_ready))
        else $error("item ready does not follow result side");

    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready && item_valid |=> item_valid && $stable(item))
        else $error("stalled item was lost");

endmodule

bind rgb_lightness_via_hsl rlh_checker u_rlh_checker (.*);

FILE: bench/tb_rgb_lightness_via_hsl.sv
// Testbench for rgb_lightness_via_hsl: random-paced stimulus, fixed-point prediction, checks.
`timescale 1ns / 1ps

module tb_rgb_lightness_via_hsl;

    localparam int  FB        = 16;
    localparam longint ONE    = longint'(1) << FB;
    localparam longint HALF   = ONE / 2;
    localparam longint K17    = (17 * ONE) / 100;
    localparam longint K33    = (33 * ONE) / 100;
    localparam longint K67    = (67 * ONE) / 100;
    localparam int  IDLE_LIMIT = 5000;
    localparam int  DRAIN_CYCLES = 2 * FB + 30;

    typedef struct {
        rlh_pkg::in_t px;
        bit  drain_first;   // hold this item until all results are back
    } pend_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic item_valid = 1'b0;
    logic item_ready;
    rlh_pkg::in_t  item = '0;
    logic result_valid;
    logic result_ready = 1'b0;
    rlh_pkg::out_t result;

    pend_t pending[$];
    rlh_pkg::out_t  expected_colors[$];
    int    errors = 0;
    int    items_sent = 0;
    int    colors_checked = 0;
    int    send_gap = 0;
    int    recv_stall = 0;
    int    idle_cycles = 0;
    bit    in_taken = 0;
    bit    out_taken = 0;
    bit    calm = 0;

    rgb_lightness_via_hsl #(.FRAC_BITS(FB)) uut (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_ready(item_ready), .item(item),
        .result_valid(result_valid), .result_ready(result_ready), .result(result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // product truncated toward zero
    function automatic longint qmul(longint a, longint b);
        longint ua;
        longint ub;
        longint m;
        ua = (a < 0) ? -a : a;
        ub = (b < 0) ? -b : b;
        m = (ua * ub) >>> FB;
        return ((a < 0) != (b < 0)) ? -m : m;
    endfunction

    function automatic longint hue_curve(longint p, longint q, longint t);
        if (t < 0)
            t += ONE;
        else if (t > ONE)
            t -= ONE;
        if (t < K17)
            return p + qmul(q - p, 6 * t);
        if (t < HALF)
            return q;
        if (t < K67)
            return p + qmul(q - p, 6 * (K67 - t));
        return p;
    endfunction

    function automatic logic [7:0] duty(longint v);
        longint x;
        if (v <= 0)
            return 8'd0;
        x = (v * 255) >>> FB;
        return (x > 255) ? 8'd255 : x[7:0];
    endfunction

    function automatic rlh_pkg::out_t predict_lightness(rlh_pkg::in_t px);
        longint r;
        longint g;
        longint b;
        longint lv;
        longint mx;
        longint mn;
        longint d;
        longint hf;
        longint lf;
        longint s;
        longint q;
        longint p;
        longint num;
        rlh_pkg::out_t o;
        r = px.red_in; g = px.green_in; b = px.blue_in; lv = px.level;
        mx = r; mn = r; hf = 0; s = 0;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        d = mx - mn;
        if (d != 0)
        begin
            if (mx == r && g >= b)
                num = g - b;
            else if (mx == r)
                num = g - b + 6 * d;
            else if (mx == g)
                num = b - r + 2 * d;
            else
                num = r - g + 4 * d;
            hf = (num << FB) / (6 * d);
        end
        if (lv > rlh_pkg::LEVEL_MAX)
            lv = rlh_pkg::LEVEL_MAX;
        lf = (lv * ONE) / 200;
        if (lf != 0 && d != 0)
        begin
            if (lf <= HALF)
                s = (d << FB) / (mx + mn);
            else
                s = (d << (2 * FB)) / (510 * (ONE - lf));
        end
        if (lf < HALF)
            q = lf + qmul(s, lf);
        else
            q = lf + s - qmul(lf, s);
        p = 2 * lf - q;
        o.red_out   = duty(hue_curve(p, q, hf + K33));
        o.green_out = duty(hue_curve(p, q, hf));
        o.blue_out  = duty(hue_curve(p, q, hf - K33));
        return o;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
        errors++;
    endtask

    task automatic queue_color(int r, int g, int b, int lv, bit drain = 0);
        pend_t e;
        e.px.red_in = 8'(r); e.px.green_in = 8'(g); e.px.blue_in = 8'(b);
        e.px.level = 8'(lv);
        e.drain_first = drain;
        pending.push_back(e);
    endtask

    function automatic int rand_level();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 3);
            1: return $urandom_range(196, 255);
            2: return $urandom_range(95, 105);
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    // sender
    always @(negedge clk)
    begin
        if (rst_n && !(item_valid && !in_taken))
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                item_valid <= 1'b0;
            end
            else if (pending.size() != 0 &&
                     !(pending[0].drain_first && expected_colors.size() != 0))
            begin
                item <= pending[0].px;
                pending.pop_front();
                item_valid <= 1'b1;
                send_gap = calm ? 0 : $urandom_range(0, 7);
            end
            else
                item_valid <= 1'b0;
        end
    end

    // receiver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_taken && !calm)
                recv_stall = $urandom_range(0, 7);
            if (recv_stall > 0)
            begin
                recv_stall--;
                result_ready <= 1'b0;
            end
            else
                result_ready <= 1'b1;
        end
    end

    // monitor and checker
    always @(posedge clk)
    begin
        rlh_pkg::out_t want;
        in_taken = rst_n && item_valid && item_ready;
        out_taken = rst_n && result_valid && result_ready;
        if (in_taken)
        begin
            expected_colors.push_back(predict_lightness(item));
            items_sent++;
            // alternate stretches of random pacing and full-rate traffic
            calm = ((items_sent / 75) % 2) == 1;
        end
        if (out_taken)
        begin
            if (expected_colors.size() == 0)
            begin
                report_mismatch("extra result", 1, 0);
            end
            else
            begin
                want = expected_colors.pop_front();
                if (result.red_out !== want.red_out)
                    report_mismatch("red_out", result.red_out, want.red_out);
                if (result.green_out !== want.green_out)
                    report_mismatch("green_out", result.green_out, want.green_out);
                if (result.blue_out !== want.blue_out)
                    report_mismatch("blue_out", result.blue_out, want.blue_out);
                colors_checked++;
            end
        end
        if (rst_n)
        begin
            idle_cycles = (in_taken || out_taken) ? 0 : idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial
    begin
        int c;
        int lo;
        // directed: greys, level extremes, each max channel and hue wrap
        queue_color(0, 0, 0, 0);
        queue_color(0, 0, 0, 255);
        queue_color(255, 255, 255, 199);
        queue_color(255, 255, 255, 200);
        queue_color(128, 128, 128, 100);
        queue_color(255, 0, 0, 100);
        queue_color(0, 255, 0, 50);
        queue_color(0, 0, 255, 150);
        queue_color(255, 0, 128, 100);
        queue_color(255, 128, 0, 180);
        queue_color(128, 255, 64, 99);
        queue_color(64, 32, 255, 101);
        queue_color(255, 255, 0, 199);
        queue_color(0, 255, 255, 1);
        queue_color(255, 0, 255, 254);
        queue_color(200, 10, 90, 0);
        queue_color(1, 0, 0, 100);
        queue_color(254, 255, 255, 170);
        queue_color(170, 85, 85, 85);
        queue_color(85, 170, 255, 255, 1);
        for (int i = 0; i < 450; i++)
        begin
            c = $urandom_range(0, 9);
            if (c == 0)
            begin
                lo = $urandom_range(0, 255);
                queue_color(lo, lo, lo, rand_level(), i % 100 == 50);
            end
            else if (c == 1)
            begin
                // extreme channel values
                queue_color($urandom_range(0, 1) * 255, $urandom_range(0, 1) * 255,
                            $urandom_range(0, 1) * 255, rand_level(), i % 100 == 50);
            end
            else
                queue_color($urandom_range(0, 255), $urandom_range(0, 255),
                            $urandom_range(0, 255), rand_level(), i % 100 == 50);
        end
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        wait (pending.size() == 0 && !item_valid);
        wait (expected_colors.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("run covered %0d colors in, %0d results checked", items_sent, colors_checked);
        $display("greys, level clamp and zero, all hue sectors, random pacing both sides");
        if (errors == 0 && expected_colors.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
